/* design/mirpd_pkg.sv */
// shared types and constants of the modulated ir presence detector
// no dependencies

package mirpd_pkg;

  localparam int unsigned SMP_W    = 10;
  localparam int unsigned THR_W    = 11;
  localparam int unsigned NUM_SENS = 3;

  localparam int unsigned SENS_LEFT  = 0;
  localparam int unsigned SENS_RIGHT = 1;
  localparam int unsigned SENS_PAPER = 2;

  // set index inside the totals and averages arrays
  localparam int unsigned SET_LIT  = 0;
  localparam int unsigned SET_DARK = 1;

  localparam logic signed [THR_W-1:0] THR_RESET = 11'sd200;

  typedef logic [SMP_W-1:0]                smp_t;
  typedef logic [NUM_SENS-1:0][SMP_W-1:0]  smp3_t;
  typedef logic signed [THR_W-1:0]         thr_t;

  typedef struct packed {
    logic vld;
    logic dark;
  } stg_ctl_t;

endpackage

/* design/mirpd_in_if.sv */
// sample input channel: valid/ready plus the three adc samples
// depends on mirpd_pkg

interface mirpd_in_if import mirpd_pkg::*; ();
  logic valid;
  logic ready;
  smp_t left_sample;
  smp_t right_sample;
  smp_t paper_sample;

  modport source (output valid, left_sample, right_sample, paper_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, paper_sample, output ready);
endinterface

/* design/mirpd_out_if.sv */
// result output channel: valid/ready plus led level and detection flags
// depends on mirpd_pkg

interface mirpd_out_if import mirpd_pkg::*; ();
  logic valid;
  logic ready;
  logic led_on;
  logic left_flag;
  logic right_flag;
  logic paper_flag;

  modport source (output valid, led_on, left_flag, right_flag, paper_flag, input ready);
  modport sink   (input valid, led_on, left_flag, right_flag, paper_flag, output ready);
endinterface

/* design/mirpd_cfg_if.sv */
// configuration write channel for the paper threshold register
// depends on mirpd_pkg

interface mirpd_cfg_if import mirpd_pkg::*; ();
  logic valid;
  logic ready;
  thr_t paper_threshold;

  modport source (output valid, paper_threshold, input ready);
  modport sink   (input valid, paper_threshold, output ready);
endinterface

/* design/mirpd_win_mem.sv */
// window sample memory, one row holds the three samples of one entry
// registered read, per-row valid bits so unwritten rows read as zero; uses mirpd_pkg

module mirpd_win_mem import mirpd_pkg::*; #(
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  smp3_t             wr_data_i,
  output smp3_t             rd_data_o
);

  localparam int unsigned DEPTH = 2**ADDR_W;

  smp3_t            mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  smp3_t            rd_data_q;
  logic             rd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_hit_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_hit_q ? rd_data_q : '0;

endmodule

/* design/mirpd_accum.sv */
// running-total update: holds the read stage, writes the new entry back
// and keeps the six window totals; uses mirpd_pkg

module mirpd_accum import mirpd_pkg::*; #(
  parameter int unsigned WINDOW = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  acc_i,
  input  logic  dark_i,
  input  logic [$clog2(WINDOW)-1:0] idx_i,
  input  smp3_t smp_i,
  input  smp3_t old_i,
  output logic  wr_en_o,
  output logic [$clog2(WINDOW):0] wr_addr_o,
  output smp3_t wr_data_o,
  output stg_ctl_t ctl_o,
  output logic [1:0][NUM_SENS-1:0][$clog2(WINDOW*(2**SMP_W-1)+1)-1:0] tot_o
);

  localparam int unsigned IDX_W = $clog2(WINDOW);
  localparam int unsigned TOT_W = $clog2(WINDOW*(2**SMP_W-1)+1);

  typedef logic [TOT_W-1:0] tot_t;

  logic             v1_q;
  logic             dark1_q;
  logic [IDX_W-1:0] idx1_q;
  smp3_t            smp1_q;
  stg_ctl_t         ctl2_q;
  tot_t [1:0][NUM_SENS-1:0] tot_q, tot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && acc_i) begin
      dark1_q <= dark_i;
      idx1_q  <= idx_i;
      smp1_q  <= smp_i;
    end
  end

  always_comb begin
    tot_d = tot_q;
    for (int s = 0; s < NUM_SENS; s++) begin
      tot_d[dark1_q][s] = tot_q[dark1_q][s] - TOT_W'(old_i[s]) + TOT_W'(smp1_q[s]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q  <= '0;
      ctl2_q <= '0;
    end else if (adv_i) begin
      ctl2_q <= '{vld: v1_q, dark: dark1_q};
      if (v1_q) begin
        tot_q <= tot_d;
      end
    end
  end

  assign wr_en_o   = adv_i && v1_q;
  assign wr_addr_o = {dark1_q, idx1_q};
  assign wr_data_o = smp1_q;
  assign ctl_o     = ctl2_q;
  assign tot_o     = tot_q;

endmodule

/* design/mirpd_avg_cmp.sv */
// averages by reciprocal multiply, then flag compare into the result register
// uses mirpd_pkg

module mirpd_avg_cmp import mirpd_pkg::*; #(
  parameter int unsigned WINDOW = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  stg_ctl_t ctl_i,
  input  logic [1:0][NUM_SENS-1:0][$clog2(WINDOW*(2**SMP_W-1)+1)-1:0] tot_i,
  input  thr_t     thr_i,
  output logic     out_valid_o,
  output logic     led_on_o,
  output logic     left_flag_o,
  output logic     right_flag_o,
  output logic     paper_flag_o
);

  localparam int unsigned IDX_W  = $clog2(WINDOW);
  localparam int unsigned TOT_W  = $clog2(WINDOW*(2**SMP_W-1)+1);
  localparam int unsigned SHIFT  = TOT_W + IDX_W;
  localparam int unsigned MULT_W = TOT_W + 2;
  localparam int unsigned PROD_W = TOT_W + MULT_W;
  localparam longint unsigned MULT = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [MULT_W-1:0] MULT_C = MULT_W'(MULT);

  stg_ctl_t ctl3_q;
  smp_t [1:0][NUM_SENS-1:0] avg_q, avg_d;
  logic [PROD_W-1:0] prod [2][NUM_SENS];

  logic out_valid_q, led_q, left_q, right_q, paper_q;
  logic signed [SMP_W+1:0] paper_diff;
  logic signed [SMP_W+1:0] thr_ext;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      for (int s = 0; s < NUM_SENS; s++) begin
        prod[p][s]  = PROD_W'(tot_i[p][s]) * PROD_W'(MULT_C);
        avg_d[p][s] = prod[p][s][SHIFT +: SMP_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else if (adv_i) begin
      ctl3_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && ctl_i.vld) begin
      avg_q <= avg_d;
    end
  end

  assign paper_diff = $signed({2'b00, avg_q[SET_DARK][SENS_PAPER]})
                    - $signed({2'b00, avg_q[SET_LIT][SENS_PAPER]});
  assign thr_ext    = {thr_i[THR_W-1], thr_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= ctl3_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && ctl3_q.vld) begin
      led_q   <= ctl3_q.dark;
      left_q  <= avg_q[SET_DARK][SENS_LEFT] != avg_q[SET_LIT][SENS_LEFT];
      right_q <= avg_q[SET_DARK][SENS_RIGHT] != avg_q[SET_LIT][SENS_RIGHT];
      paper_q <= paper_diff > thr_ext;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign led_on_o     = led_q;
  assign left_flag_o  = left_q;
  assign right_flag_o = right_q;
  assign paper_flag_o = paper_q;

endmodule

/* design/modulated_ir_presence_detector.sv */
// an accepted transaction passes the read stage, totals, averages and result registers
// in turn; one transaction per cycle when out_ch.ready does not stall, set by the single
// read-modify-write of the window memory per tick (write phase never equals read phase)
// reset: phase, ring index, totals and memory row valid bits clear at once, so
// every window reads as zero; threshold resets to 200; no clearing pass needed
// depends on mirpd_pkg, mirpd interfaces, mirpd_win_mem, mirpd_accum, mirpd_avg_cmp

module modulated_ir_presence_detector import mirpd_pkg::*; #(
  parameter int unsigned WINDOW = 8
) (
  input logic          clk_i,
  input logic          rst_ni,
  mirpd_in_if.sink     in_ch,
  mirpd_out_if.source  out_ch,
  mirpd_cfg_if.sink    cfg_ch
);

  localparam int unsigned IDX_W  = $clog2(WINDOW);
  localparam int unsigned ADDR_W = IDX_W + 1;
  localparam int unsigned TOT_W  = $clog2(WINDOW*(2**SMP_W-1)+1);

  logic             phase_q, phase_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  thr_t             thr_q;

  logic  adv, accept, out_valid;
  smp3_t smp_in, rd_data, wr_data;
  logic  wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  stg_ctl_t ctl2;
  logic [1:0][NUM_SENS-1:0][TOT_W-1:0] tot;

  assign adv          = !out_valid || out_ch.ready;
  assign in_ch.ready  = adv;
  assign accept       = adv && in_ch.valid;
  assign cfg_ch.ready = 1'b1;

  assign smp_in[SENS_LEFT]  = in_ch.left_sample;
  assign smp_in[SENS_RIGHT] = in_ch.right_sample;
  assign smp_in[SENS_PAPER] = in_ch.paper_sample;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    if (accept) begin
      phase_d = ~phase_q;
      idx_d   = (idx_q == IDX_W'(WINDOW - 1)) ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      idx_q   <= '0;
      thr_q   <= THR_RESET;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      if (cfg_ch.valid) begin
        thr_q <= cfg_ch.paper_threshold;
      end
    end
  end

  assign rd_addr = {phase_q, idx_q};

  mirpd_win_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  mirpd_accum #(
    .WINDOW (WINDOW)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .acc_i     (accept),
    .dark_i    (phase_q),
    .idx_i     (idx_q),
    .smp_i     (smp_in),
    .old_i     (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .ctl_o     (ctl2),
    .tot_o     (tot)
  );

  mirpd_avg_cmp #(
    .WINDOW (WINDOW)
  ) u_avg_cmp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .ctl_i        (ctl2),
    .tot_i        (tot),
    .thr_i        (thr_q),
    .out_valid_o  (out_valid),
    .led_on_o     (out_ch.led_on),
    .left_flag_o  (out_ch.left_flag),
    .right_flag_o (out_ch.right_flag),
    .paper_flag_o (out_ch.paper_flag)
  );

  assign out_ch.valid = out_valid;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, idx_q} < ADDR_W'(WINDOW))
    else $error("ring index out of range");

  a_phase_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> phase_q != $past(phase_q))
    else $error("phase did not alternate on transaction");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && accept) |-> wr_addr != rd_addr)
    else $error("memory read and write hit the same row");

endmodule

/* dv/tb.sv */
// testbench of the modulated ir presence detector: random and directed sample ticks
// checked against an in-bench window predictor; depends on mirpd_pkg,
// the mirpd channel interfaces and modulated_ir_presence_detector
`timescale 1ns / 100ps

module tb;
  import mirpd_pkg::*;

  localparam int unsigned WINDOW = 8;

  typedef struct packed {
    logic led_on;
    logic left_flag;
    logic right_flag;
    logic paper_flag;
  } flags_t;

  class detector_scoreboard;
    thr_t                 threshold;
    logic                 phase_dark;
    int unsigned          ring_idx;
    logic [SMP_W-1:0]     dark_win [NUM_SENS][WINDOW];
    logic [SMP_W-1:0]     lit_win  [NUM_SENS][WINDOW];
    int unsigned          dark_sum [NUM_SENS];
    int unsigned          lit_sum  [NUM_SENS];
    flags_t               expected_flags [$];
    int unsigned          mismatches;

    function new();
      threshold  = THR_RESET;
      phase_dark = 1'b0;
      ring_idx   = 0;
      mismatches = 0;
      for (int k = 0; k < NUM_SENS; k++) begin
        dark_sum[k] = 0;
        lit_sum[k]  = 0;
        for (int j = 0; j < WINDOW; j++) begin
          dark_win[k][j] = '0;
          lit_win[k][j]  = '0;
        end
      end
    endfunction

    function void set_threshold(thr_t value);
      threshold = value;
    endfunction

    function int unsigned pending();
      return expected_flags.size();
    endfunction

    // one tick: store the samples in the current phase's windows, then compare averages
    function void note_samples(smp3_t smp);
      flags_t f;
      int     davg [NUM_SENS];
      int     lavg [NUM_SENS];
      for (int k = 0; k < NUM_SENS; k++) begin
        if (phase_dark) begin
          dark_sum[k] = dark_sum[k] - dark_win[k][ring_idx] + smp[k];
          dark_win[k][ring_idx] = smp[k];
        end else begin
          lit_sum[k] = lit_sum[k] - lit_win[k][ring_idx] + smp[k];
          lit_win[k][ring_idx] = smp[k];
        end
      end
      f.led_on   = phase_dark;
      phase_dark = ~phase_dark;
      ring_idx   = (ring_idx == WINDOW - 1) ? 0 : ring_idx + 1;
      for (int k = 0; k < NUM_SENS; k++) begin
        davg[k] = dark_sum[k] / WINDOW;
        lavg[k] = lit_sum[k] / WINDOW;
      end
      f.left_flag  = (davg[SENS_LEFT] != lavg[SENS_LEFT]);
      f.right_flag = (davg[SENS_RIGHT] != lavg[SENS_RIGHT]);
      f.paper_flag = (davg[SENS_PAPER] - lavg[SENS_PAPER] > int'(threshold));
      expected_flags.push_back(f);
    endfunction

    function void check_result(flags_t got);
      flags_t exp_f;
      if (expected_flags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: got %b", got);
        return;
      end
      exp_f = expected_flags.pop_front();
      if (got.led_on !== exp_f.led_on || got.left_flag !== exp_f.left_flag ||
          got.right_flag !== exp_f.right_flag || got.paper_flag !== exp_f.paper_flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch led/left/right/paper: expected %b%b%b%b got %b%b%b%b",
                   exp_f.led_on, exp_f.left_flag, exp_f.right_flag, exp_f.paper_flag,
                   got.led_on, got.left_flag, got.right_flag, got.paper_flag);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic calm;

  mirpd_in_if  in_ch ();
  mirpd_out_if out_ch ();
  mirpd_cfg_if cfg_ch ();

  detector_scoreboard sb;

  modulated_ir_presence_detector #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #200000;
    $display("tb NOT OK");
    $finish;
  end

  // result side: random back-pressure, check every transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.led_on, out_ch.left_flag, out_ch.right_flag, out_ch.paper_flag});
    out_ch.ready <= calm || ($urandom_range(99) >= 38);
  end

  function automatic smp_t clamp_smp(int v);
    if (v < 0) return '0;
    if (v > 1023) return smp_t'(1023);
    return smp_t'(v);
  endfunction

  task automatic send_samples(smp_t l, smp_t r, smp_t p);
    if (!calm) begin
      while ($urandom_range(99) < 38) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.left_sample  <= l;
    in_ch.right_sample <= r;
    in_ch.paper_sample <= p;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_samples({p, r, l});
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_threshold(thr_t value);
    drain();
    cfg_ch.valid           <= 1'b1;
    cfg_ch.paper_threshold <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_threshold(value);
  endtask

  // chunks of well-formed steady levels per phase, plus extremes and noise
  task automatic random_phase(int unsigned n_items);
    int unsigned sent;
    int unsigned chunk;
    int unsigned mode;
    int          lit_lvl  [NUM_SENS];
    int          dark_lvl [NUM_SENS];
    int          lvl      [NUM_SENS];
    smp_t        v        [NUM_SENS];
    int unsigned noise;
    sent = 0;
    while (sent < n_items) begin
      chunk = $urandom_range(8, 40);
      mode  = $urandom_range(0, 3);
      for (int k = 0; k < NUM_SENS; k++) begin
        lit_lvl[k]  = $urandom_range(0, 1023);
        dark_lvl[k] = ($urandom_range(0, 1) == 1) ? lit_lvl[k] : $urandom_range(0, 1023);
      end
      if ($urandom_range(0, 1) == 1)
        dark_lvl[SENS_PAPER] = lit_lvl[SENS_PAPER] + 2 * int'(sb.threshold)
                               + $urandom_range(0, 6) - 3;
      noise = $urandom_range(0, 2);
      for (int i = 0; i < chunk && sent < n_items; i++) begin
        for (int k = 0; k < NUM_SENS; k++) begin
          case (mode)
            0: begin
              v[k] = smp_t'($urandom_range(0, 1023));
            end
            1: begin
              case ($urandom_range(0, 3))
                0: v[k] = smp_t'(0);
                1: v[k] = smp_t'(1023);
                2: v[k] = smp_t'(511);
                default: v[k] = smp_t'(512);
              endcase
            end
            default: begin
              lvl[k] = sb.phase_dark ? dark_lvl[k] : lit_lvl[k];
              v[k] = clamp_smp(lvl[k] + int'($urandom_range(0, 2 * noise)) - int'(noise));
            end
          endcase
        end
        send_samples(v[SENS_LEFT], v[SENS_RIGHT], v[SENS_PAPER]);
        sent++;
      end
    end
  endtask

  initial begin
    thr_t thr_list [8];
    sb = new();
    thr_list = '{-11'sd1024, 11'sd1023, 11'sd0, -11'sd1, 11'sd1, 11'sd511, -11'sd511, 11'sd100};
    calm                   = 1'b0;
    rst_ni                 = 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.left_sample     <= '0;
    in_ch.right_sample    <= '0;
    in_ch.paper_sample    <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.paper_threshold <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero and full-scale ticks, large positive and negative paper margins,
    // then equal levels so every flag clears with the skipped entries still zero
    send_samples(0, 0, 0);
    send_samples(0, 0, 0);
    send_samples(1023, 1023, 1023);
    send_samples(1023, 1023, 1023);
    repeat (3) begin
      send_samples(0, 0, 0);
      send_samples(1023, 0, 1023);
    end
    repeat (3) begin
      send_samples(1023, 1023, 1023);
      send_samples(0, 1023, 0);
    end
    repeat (4) begin
      send_samples(300, 300, 300);
      send_samples(300, 300, 300);
    end

    for (int ph = 0; ph < 13; ph++) begin
      if (ph < 8)
        write_threshold(thr_list[ph]);
      else
        write_threshold(thr_t'($urandom_range(0, 2047)));
      calm = (ph == 3);
      random_phase(75);
      if (ph == 6)
        drain();
      random_phase(75);
    end
    calm = 1'b0;
    write_threshold(THR_RESET);
    random_phase(40);

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
design/mirpd_pkg.sv
design/mirpd_in_if.sv
design/mirpd_out_if.sv
design/mirpd_cfg_if.sv
design/mirpd_win_mem.sv
design/mirpd_accum.sv
design/mirpd_avg_cmp.sv
design/modulated_ir_presence_detector.sv
dv/tb.sv
